// File: rtl/bb3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_pkg: shared constants and types of the 3x3 box blur
// Frame geometry, counter widths, the reciprocal used to divide by nine and
// the control group that travels from the window stage to the mean stage.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int FRAME_SIDE = 256;
	localparam int COL_W      = $clog2(FRAME_SIDE);
	localparam int ROW_W      = $clog2(FRAME_SIDE + 2);
	localparam int PIX_W      = 8;

	// nine pixels of at most 255 sum to at most 2295
	localparam int SUM_W       = 12;
	// floor(sum * 7282 / 2^16) equals floor(sum / 9) for every sum below 2304
	localparam int RECIP_NINE  = 7282;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = SUM_W + RECIP_W;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_PAD   = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;
	// index = column * 3 + row, column 0 oldest, row 0 top
	typedef pix_t [8:0] win_t;

	typedef struct packed {
		logic no_top;
		logic no_bottom;
		logic no_left;
		logic no_right;
	} mask_t;

	typedef struct packed {
		logic  valid;
		logic  last;
		mask_t mask;
	} ctl_t;

endpackage
`default_nettype wire

// File: rtl/box_blur_3x3_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_core: streaming 3x3 mean filter
// Raster-order grayscale pixels in, one mean of each 3x3 neighbourhood out,
// with neighbours outside the frame counted as zero.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------
//  input   | in_valid / in_stall  | operation (pixel or pad), pixel
//  output  | out_valid / out_stall| blurred_pixel, last_of_frame
//
// One transfer per cycle on either side when not stalled. A result goes
// from the window stage via the sum register to the result register; the
// centre at (r, c) is completed by the item FRAME_SIDE+1 places later in the
// stream, and FRAME_SIDE+1 pad ticks after the frame drain the final row.
// Reset clears the window, position and pipeline flags; the line stores are
// not cleared, since every word that stands outside the frame is masked.
// Stall holds only the stage concerned: input is taken while the result
// register waits, and in_stall rises only once window, sum and result
// stages all hold a result.
// ----------------------------------------------------------------------------
module box_blur_3x3_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output      logic          in_stall,
	input  wire logic          operation,
	input  wire bb3_pkg::pix_t pixel,
	output      logic          out_valid,
	input  wire logic          out_stall,
	output      bb3_pkg::pix_t blurred_pixel,
	output      logic          last_of_frame
);
	import bb3_pkg::*;

	ctl_t ctl_s1;
	win_t win_s1;
	logic s2_ready;

	// line stores, window shift and border masks
	bb3_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.pixel     (pixel),
		.s2_ready  (s2_ready),
		.ctl_s1    (ctl_s1),
		.win_s1    (win_s1)
	);

	// masked sum, then divide by nine into the result register
	bb3_mean u_mean (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl_s1        (ctl_s1),
		.win_s1        (win_s1),
		.s2_ready      (s2_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.blurred_pixel (blurred_pixel),
		.last_of_frame (last_of_frame)
	);

endmodule
`default_nettype wire

// File: rtl/bb3_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bb3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// File: rtl/bb3_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_window: line stores, 3x3 window and stream position
// Takes one transfer per cycle unless stalled, drops in-frame pad ticks, shifts
// the window and flags which centre, if any, it yields, with its border masks.
// ----------------------------------------------------------------------------
module bb3_window (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output      logic         in_stall,
	input  wire logic         operation,
	input  wire bb3_pkg::pix_t pixel,
	input  wire logic         s2_ready,
	output      bb3_pkg::ctl_t ctl_s1,
	output      bb3_pkg::win_t win_s1
);
	import bb3_pkg::*;

	localparam logic [ROW_W-1:0] ROW_ONE   = ROW_W'(1);
	localparam logic [ROW_W-1:0] ROW_TWO   = ROW_W'(2);
	localparam logic [ROW_W-1:0] ROW_FRAME = ROW_W'(FRAME_SIDE);
	localparam logic [ROW_W-1:0] ROW_DRAIN = ROW_W'(FRAME_SIDE + 1);
	localparam logic [COL_W-1:0] COL_ONE   = COL_W'(1);
	localparam logic [COL_W-1:0] COL_LAST  = COL_W'(FRAME_SIDE - 1);

	logic [ROW_W-1:0] row_q, row_next;
	logic [COL_W-1:0] col_q, col_next;
	logic             s1_ready, accept, in_frame, ignored, work, drain_end;
	logic             edge_emit, centre_emit;
	pix_t             v, upper_rd, lower_rd;
	ctl_t             ctl_next;

	assign s1_ready  = !ctl_s1.valid || s2_ready;
	assign in_stall  = !s1_ready;
	assign accept    = in_valid && s1_ready;
	assign in_frame  = row_q < ROW_FRAME;
	assign ignored   = (operation == OP_PAD) && in_frame;
	assign work      = accept && !ignored;
	assign drain_end = row_q == ROW_DRAIN;
	assign v         = in_frame ? pixel : '0;

	always_comb begin
		row_next = row_q;
		col_next = col_q;
		if (work) begin
			if (drain_end) begin
				row_next = '0;
				col_next = '0;
			end else if (col_q == COL_LAST) begin
				col_next = '0;
				row_next = row_q + ROW_ONE;
			end else begin
				col_next = col_q + COL_ONE;
			end
		end
	end

	// right-edge centre of the row two above at column zero, else centre (r-1, c-1)
	assign edge_emit   = (col_q == '0) && (row_q >= ROW_TWO);
	assign centre_emit = (col_q != '0) && (row_q != '0);

	always_comb begin
		ctl_next.valid          = work && (edge_emit || centre_emit);
		ctl_next.last           = drain_end;
		ctl_next.mask.no_top    = edge_emit ? (row_q == ROW_TWO) : (row_q == ROW_ONE);
		ctl_next.mask.no_bottom = !edge_emit && (row_q == ROW_FRAME);
		ctl_next.mask.no_left   = !edge_emit && (col_q == COL_ONE);
		ctl_next.mask.no_right  = edge_emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			ctl_s1 <= '0;
			win_s1 <= '0;
		end else begin
			row_q <= row_next;
			col_q <= col_next;
			if (s1_ready) begin
				ctl_s1 <= ctl_next;
			end
			if (work) begin
				win_s1[5:0] <= win_s1[8:3];
				win_s1[6]   <= upper_rd;
				win_s1[7]   <= lower_rd;
				win_s1[8]   <= v;
			end
		end
	end

	// read ahead at the column of the next transfer
	bb3_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_SIDE)) u_upper (
		.clk     (clk),
		.we      (work && !drain_end),
		.wr_addr (col_q),
		.wr_data (lower_rd),
		.rd_addr (col_next),
		.rd_data (upper_rd)
	);

	bb3_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_SIDE)) u_lower (
		.clk     (clk),
		.we      (work && !drain_end),
		.wr_addr (col_q),
		.wr_data (v),
		.rd_addr (col_next),
		.rd_data (lower_rd)
	);

endmodule
`default_nettype wire

// File: rtl/bb3_mean.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_mean: masked window sum and division by nine
// Sums the unmasked window pixels into a stage register, then divides by a
// reciprocal multiply into the result register.
// ----------------------------------------------------------------------------
module bb3_mean (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bb3_pkg::ctl_t ctl_s1,
	input  wire bb3_pkg::win_t win_s1,
	output      logic          s2_ready,
	output      logic          out_valid,
	input  wire logic          out_stall,
	output      bb3_pkg::pix_t blurred_pixel,
	output      logic          last_of_frame
);
	import bb3_pkg::*;

	logic              out_ready, valid_s2, last_s2;
	logic [SUM_W-1:0]  sum_next, sum_s2;
	logic [PROD_W-1:0] prod;
	logic [2:0]        keep_col, keep_row;

	assign out_ready = !out_valid || !out_stall;
	assign s2_ready  = !valid_s2 || out_ready;

	assign keep_col = {!ctl_s1.mask.no_right, 1'b1, !ctl_s1.mask.no_left};
	assign keep_row = {!ctl_s1.mask.no_bottom, 1'b1, !ctl_s1.mask.no_top};

	always_comb begin
		sum_next = '0;
		for (int col = 0; col < 3; col++) begin
			for (int row = 0; row < 3; row++) begin
				if (keep_col[col] && keep_row[row]) begin
					sum_next = sum_next + SUM_W'(win_s1[col * 3 + row]);
				end
			end
		end
	end

	assign prod = PROD_W'(sum_s2) * PROD_W'(RECIP_NINE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (s2_ready) begin
				valid_s2 <= ctl_s1.valid;
			end
			if (out_ready) begin
				out_valid <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && ctl_s1.valid) begin
			sum_s2  <= sum_next;
			last_s2 <= ctl_s1.last;
		end
		if (out_ready && valid_s2) begin
			blurred_pixel <= prod[RECIP_SHIFT +: PIX_W];
			last_of_frame <= last_s2;
		end
	end

endmodule
`default_nettype wire

// File: rtl/bb3_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_checker: port-level checks of the box blur
// Output hold under stall, input stall only while the output is stalled, idle in reset.
// ----------------------------------------------------------------------------
module bb3_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_stall,
	input wire logic          out_valid,
	input wire logic          out_stall,
	input wire bb3_pkg::pix_t blurred_pixel,
	input wire logic          last_of_frame
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(blurred_pixel) && $stable(last_of_frame))
		else $error("result changed while stalled");

	a_stall_full: assert property (@(posedge clk)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room in the pipeline");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid && !in_stall)
		else $error("handshake active during reset");

endmodule

bind box_blur_3x3_core bb3_checker u_checker (.*);
`default_nettype wire

// File: tb/tb_box_blur_3x3_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_core: self-checking bench for the streaming 3x3 mean filter
// Streams the opening rows of a raster-order frame, with stray pad ticks
// inside the frame, so that the top border, the left border and the
// right-edge centre all come out. A cycle-free predictor follows each
// accepted transfer and queues the mean it should produce, and every result
// transfer is checked in order against it. Both handshakes idle and stall at
// random, and the result side holds off twice for a long stretch.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_core;

	import bb3_pkg::*;

	localparam int SIDE           = FRAME_SIDE;
	localparam int NEIGHBOURS     = 9;
	// input transfers offered over the whole run
	localparam int ITEM_COUNT     = 550;
	// quiet stretch of the final part of the run, counted in pending items
	localparam int CALM_ITEMS     = 60;
	// longest receiver hold-off, far below the watchdog limit
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	// result register lies behind the window and sum stages; allow for margin
	localparam int TAIL_CYCLES    = 16;
	localparam int MAX_REPORTS    = 10;

	typedef enum int {
		FILL_RANDOM,
		FILL_FULL,
		FILL_EXTREME
	} fill_mode_t;

	typedef struct {
		logic op;
		pix_t px;
	} blur_item_t;

	typedef struct {
		pix_t value;
		logic last;
	} blur_mean_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic operation;
	pix_t pixel;
	logic out_valid;
	logic out_stall;
	pix_t blurred_pixel;
	logic last_of_frame;

	box_blur_3x3_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.pixel         (pixel),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.blurred_pixel (blurred_pixel),
		.last_of_frame (last_of_frame)
	);

	// items still to be offered, and means still to come out of the block
	blur_item_t frame_items[$];
	blur_mean_t blur_expected[$];

	// predictor state: two line stores, the 3x3 window, the stream position
	pix_t        line_upper[SIDE];
	pix_t        line_lower[SIDE];
	pix_t        win[9];
	int unsigned row_pos;
	int unsigned col_pos;

	int         failures;
	int         results_seen;
	int         quiet_cycles;
	int         tx_gap;
	int         rx_gap;
	int         hold_left;
	int         hold_marks[$];
	logic       in_taken;
	logic       calm;
	blur_item_t next_item;

	always #1 clk = ~clk;

	// Mean of the window over columns first_col..2, with the top or bottom
	// row dropped where it lies outside the frame.
	function automatic pix_t window_mean(input int first_col, input logic no_top,
			input logic no_bottom);
		int unsigned sum;
		int          col;
		int          row;
		sum = 0;
		for (col = first_col; col < 3; col++) begin
			for (row = no_top ? 1 : 0; row < (no_bottom ? 2 : 3); row++) begin
				sum += win[col*3 + row];
			end
		end
		return pix_t'(sum / NEIGHBOURS);
	endfunction

	// Advance the predictor by one accepted transfer and queue what it yields.
	task automatic blur_predict(input logic op, input pix_t px);
		int unsigned r;
		int unsigned c;
		int          i;
		pix_t        v;
		pix_t        above2;
		pix_t        above1;
		r = row_pos;
		c = col_pos;
		// a pad tick inside the frame changes nothing
		if (!(op == OP_PAD && r < SIDE)) begin
			// during the drain every item counts as a pad of zero
			v = (r < SIDE) ? px : '0;
			// column zero releases the right-edge centre two rows up
			if (c == 0 && r >= 2) begin
				blur_expected.push_back('{window_mean(1, r == 2, 1'b0), r == SIDE + 1});
			end
			if (r >= SIDE + 1) begin
				row_pos = 0;
				col_pos = 0;
			end else begin
				above2 = line_upper[c];
				above1 = line_lower[c];
				line_upper[c] = above1;
				line_lower[c] = v;
				for (i = 0; i < 6; i++) begin
					win[i] = win[i+3];
				end
				win[6] = above2;
				win[7] = above1;
				win[8] = v;
				if (c >= 1 && r >= 1) begin
					blur_expected.push_back('{window_mean((c == 1) ? 1 : 0, r == 1, r == SIDE),
						1'b0});
				end
				c++;
				if (c >= SIDE) begin
					c = 0;
					r++;
				end
				row_pos = r;
				col_pos = c;
			end
		end
	endtask

	// Queue one whole frame, its drain and a few pad ticks after it.
	task automatic queue_frame(input fill_mode_t mode, input logic opening);
		int   r;
		int   c;
		int   k;
		pix_t px;
		pix_t head[12];
		head = '{8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd1, 8'd254, 8'd128,
			8'd127, 8'd0, 8'd255, 8'd0};
		for (r = 0; r < SIDE; r++) begin
			for (c = 0; c < SIDE; c++) begin
				// stray pad tick inside the frame: the block should drop it
				if ($urandom_range(0, 63) == 0) begin
					frame_items.push_back('{OP_PAD, pix_t'($urandom_range(0, 255))});
				end
				case (mode)
					FILL_FULL: begin
						px = 8'd255;
					end
					FILL_EXTREME: begin
						case ($urandom_range(0, 2))
							0: px = 8'd0;
							1: px = 8'd255;
							default: px = pix_t'($urandom_range(0, 255));
						endcase
					end
					default: begin
						px = pix_t'($urandom_range(0, 255));
					end
				endcase
				if (opening && r == 0 && c < 12) begin
					px = head[c];
				end
				frame_items.push_back('{OP_PIXEL, px});
			end
		end
		// drain: mostly pad ticks, now and then a pixel whose value is lost
		for (k = 0; k < SIDE + 1; k++) begin
			if ($urandom_range(0, 7) == 0) begin
				frame_items.push_back('{OP_PIXEL, pix_t'($urandom_range(0, 255))});
			end else begin
				frame_items.push_back('{OP_PAD, pix_t'($urandom_range(0, 255))});
			end
		end
		// pad ticks between frames do no harm
		for (k = $urandom_range(0, 3); k > 0; k--) begin
			frame_items.push_back('{OP_PAD, pix_t'($urandom_range(0, 255))});
		end
	endtask

	// Input side, sampling: note each transfer at the rising edge and feed
	// it to the predictor.
	always @(posedge clk) begin
		in_taken = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			in_taken = 1'b1;
			blur_predict(operation, pixel);
		end
	end

	// Input side, driving: offer the next item at the falling edge once the
	// current one has gone. Hold the payload while stalled, and idle only
	// between items so that valid never follows stall.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (frame_items.size() == 0) begin
				in_valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				// random idle burst before the next item
				tx_gap = $urandom_range(0, 4);
				in_valid <= 1'b0;
			end else begin
				next_item = frame_items.pop_front();
				in_valid  <= 1'b1;
				operation <= next_item.op;
				pixel     <= next_item.px;
			end
			calm <= frame_items.size() < CALM_ITEMS;
		end
	end

	// Output side, stall: random bursts, plus a long hold-off at each mark so
	// that window, sum and result stages all fill and the input stalls.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left == 0 && hold_marks.size() > 0 && results_seen >= hold_marks[0]) begin
				void'(hold_marks.pop_front());
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				rx_gap = $urandom_range(0, 4);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Output side, checking: compare each result transfer with the oldest
	// expected mean.
	always @(posedge clk) begin : result_check
		blur_mean_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (blur_expected.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$display("unexpected result %0d: blurred_pixel %0d last_of_frame %0b",
						results_seen, blurred_pixel, last_of_frame);
				end
			end else begin
				want = blur_expected.pop_front();
				if (blurred_pixel !== want.value || last_of_frame !== want.last) begin
					failures++;
					if (failures <= MAX_REPORTS) begin
						$display({"mismatch at result %0d: blurred_pixel %0d (expected %0d), ",
							"last_of_frame %0b (expected %0b)"},
							results_seen, blurred_pixel, want.value,
							last_of_frame, want.last);
					end
				end
			end
		end
	end

	// Watchdog: count cycles without any transfer on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int i;
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = OP_PIXEL;
		pixel        = '0;
		out_stall    = 1'b0;
		in_taken     = 1'b0;
		calm         = 1'b0;
		failures     = 0;
		results_seen = 0;
		quiet_cycles = 0;
		tx_gap       = 0;
		rx_gap       = 0;
		hold_left    = 0;
		row_pos      = 0;
		col_pos      = 0;
		for (i = 0; i < SIDE; i++) begin
			line_upper[i] = '0;
			line_lower[i] = '0;
		end
		for (i = 0; i < 9; i++) begin
			win[i] = '0;
		end
		hold_marks.push_back(20);
		hold_marks.push_back(150);

		// pad ticks before the first frame must be dropped
		frame_items.push_back('{OP_PAD, 8'd0});
		frame_items.push_back('{OP_PAD, 8'd255});
		frame_items.push_back('{OP_PAD, pix_t'($urandom_range(0, 255))});
		// the frame opens with extreme values; keep only its first rows
		queue_frame(FILL_RANDOM, 1'b1);
		while (frame_items.size() > ITEM_COUNT) begin
			void'(frame_items.pop_back());
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: wait for every item to go in and every mean to come out
		while (!(frame_items.size() == 0 && !in_valid && blur_expected.size() == 0)) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		#0.1;
		if (failures == 0 && blur_expected.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
